[rtl/slx_pkg.sv]
// Shared types, codes and character helpers for the script lexer.
package slx_pkg;

  // Lexer mode, one-hot
  typedef enum logic [5:0] {
    ModeIdle    = 6'b000001,
    ModeComment = 6'b000010,
    ModeSlash   = 6'b000100,
    ModeWord    = 6'b001000,
    ModeString  = 6'b010000,
    ModeQuote   = 6'b100000
  } lex_mode_e;

  // Record kinds
  typedef enum logic [1:0] {
    RecChar = 2'd0,
    RecEnd  = 2'd1,
    RecErr  = 2'd2
  } rec_type_e;

  // Token classes
  typedef enum logic [1:0] {
    ClsWord = 2'd0,
    ClsOp   = 2'd1,
    ClsStr  = 2'd2
  } tok_class_e;

  localparam logic [7:0]  CharQuote   = 8'h22;
  localparam logic [7:0]  CharSlash   = 8'h2F;
  localparam logic [7:0]  CharNewline = 8'h0A;
  localparam logic [19:0] CntLimit    = 20'hFFFFF;
  localparam int unsigned MaxRecs     = 4;

  // One result record (last_of_run is added at the output stage)
  typedef struct packed {
    rec_type_e   rtype;
    tok_class_e  cls;
    logic [7:0]  ch;
    logic [19:0] len;
    logic [15:0] line;
    logic [19:0] off;
  } rec_t;

  // Status of the record group buffer
  typedef struct packed {
    logic [2:0] cnt;
    logic       can_load;
  } grp_st_t;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0D, 8'h0A};
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return c inside {8'h2C, 8'h3D, 8'h28, 8'h29, 8'h3B, 8'h7B, 8'h7D,
                     8'h3C, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3E};
  endfunction

  function automatic rec_t mk_rec(input rec_type_e rtype, input tok_class_e cls,
                                  input logic [7:0] ch, input logic [19:0] len,
                                  input logic [15:0] line, input logic [19:0] off);
    rec_t r;
    r.rtype = rtype;
    r.cls   = cls;
    r.ch    = ch;
    r.len   = len;
    r.line  = line;
    r.off   = off;
    return r;
  endfunction

endpackage

[rtl/slx_core.sv]
// Lexer state registers and the per-byte record generation logic.
module slx_core import slx_pkg::*; #(
  parameter int unsigned MAX_SCRIPT_BYTES = 1048576,
  parameter int unsigned MAX_LINES        = 65536
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            acc_i,
  input  logic [7:0]      byte_i,
  input  logic            fin_i,
  output rec_t [3:0]      recs_o,
  output logic [2:0]      cnt_o
);

  localparam logic [19:0] PosLimit  = (MAX_SCRIPT_BYTES > 32'h100000) ? 20'hFFFFF
                                      : 20'(MAX_SCRIPT_BYTES - 1);
  localparam logic [15:0] LineLimit = (MAX_LINES > 32'h10000) ? 16'hFFFF
                                      : 16'(MAX_LINES - 1);

  lex_mode_e   mode_q, mode_d;
  logic [15:0] line_q, line_d, line_inc;
  logic [19:0] pos_q, pos_d, pos_inc;
  logic [19:0] start_q, start_d;
  logic [19:0] cnt_q, cnt_d, cnt_inc;
  logic [2:0]  k;
  logic        do_idle;
  rec_t [3:0]  recs;

  // Saturating increments
  assign line_inc = (line_q >= LineLimit) ? LineLimit : line_q + 16'd1;
  assign pos_inc  = (pos_q >= PosLimit) ? PosLimit : pos_q + 20'd1;
  assign cnt_inc  = (cnt_q >= CntLimit) ? CntLimit : cnt_q + 20'd1;

  // Next state and records for the byte on the input
  always_comb begin
    recs    = '0;
    k       = '0;
    mode_d  = mode_q;
    line_d  = line_q;
    start_d = start_q;
    cnt_d   = cnt_q;
    do_idle = 1'b0;

    unique case (mode_q)
      ModeComment: begin
        if (byte_i == CharNewline) begin
          mode_d = ModeIdle;
          line_d = line_inc;
        end
      end
      ModeSlash: begin
        if (byte_i == CharSlash) begin
          mode_d = ModeComment;
        end else begin
          recs[k[1:0]] = mk_rec(RecChar, ClsOp, CharSlash, 20'd0, line_q, start_q);
          k = k + 3'd1;
          recs[k[1:0]] = mk_rec(RecEnd, ClsOp, 8'd0, 20'd1, line_q, start_q);
          k = k + 3'd1;
          do_idle = 1'b1;
        end
      end
      ModeWord: begin
        if (is_space(byte_i) || is_op(byte_i)) begin
          recs[k[1:0]] = mk_rec(RecEnd, ClsWord, 8'd0, cnt_q, line_q, start_q);
          k = k + 3'd1;
          do_idle = 1'b1;
        end else begin
          cnt_d = cnt_inc;
          recs[k[1:0]] = mk_rec(RecChar, ClsWord, byte_i, 20'd0, line_q, start_q);
          k = k + 3'd1;
        end
      end
      ModeString: begin
        if (byte_i == CharQuote) begin
          mode_d = ModeQuote;
        end else begin
          cnt_d = cnt_inc;
          recs[k[1:0]] = mk_rec(RecChar, ClsStr, byte_i, 20'd0, line_q, start_q);
          k = k + 3'd1;
        end
      end
      ModeQuote: begin
        if (byte_i == CharQuote) begin
          // doubled quote stands for one quote character
          mode_d = ModeString;
          cnt_d  = cnt_inc;
          recs[k[1:0]] = mk_rec(RecChar, ClsStr, CharQuote, 20'd0, line_q, start_q);
          k = k + 3'd1;
        end else begin
          recs[k[1:0]] = mk_rec(RecEnd, ClsStr, 8'd0, cnt_q, line_q, pos_q);
          k = k + 3'd1;
          do_idle = 1'b1;
        end
      end
      default: do_idle = 1'b1;
    endcase

    // Byte seen between tokens
    if (do_idle) begin
      mode_d = ModeIdle;
      if (is_space(byte_i)) begin
        if (byte_i == CharNewline) line_d = line_inc;
      end else if (byte_i == CharSlash) begin
        mode_d  = ModeSlash;
        start_d = pos_q;
      end else if (is_op(byte_i)) begin
        recs[k[1:0]] = mk_rec(RecChar, ClsOp, byte_i, 20'd0, line_q, pos_q);
        k = k + 3'd1;
        recs[k[1:0]] = mk_rec(RecEnd, ClsOp, 8'd0, 20'd1, line_q, pos_q);
        k = k + 3'd1;
      end else if (byte_i == CharQuote) begin
        mode_d  = ModeString;
        start_d = pos_q;
        cnt_d   = 20'd0;
      end else begin
        mode_d  = ModeWord;
        start_d = pos_q;
        cnt_d   = 20'd1;
        recs[k[1:0]] = mk_rec(RecChar, ClsWord, byte_i, 20'd0, line_q, pos_q);
        k = k + 3'd1;
      end
    end

    pos_d = pos_inc;

    // Close whatever is open on the last byte, then restart
    if (fin_i) begin
      unique case (mode_d)
        ModeSlash: begin
          recs[k[1:0]] = mk_rec(RecChar, ClsOp, CharSlash, 20'd0, line_d, start_d);
          k = k + 3'd1;
          recs[k[1:0]] = mk_rec(RecEnd, ClsOp, 8'd0, 20'd1, line_d, start_d);
          k = k + 3'd1;
        end
        ModeWord: begin
          recs[k[1:0]] = mk_rec(RecEnd, ClsWord, 8'd0, cnt_d, line_d, start_d);
          k = k + 3'd1;
        end
        ModeString: begin
          recs[k[1:0]] = mk_rec(RecErr, ClsStr, 8'd0, cnt_d, line_d, start_d);
          k = k + 3'd1;
        end
        ModeQuote: begin
          recs[k[1:0]] = mk_rec(RecEnd, ClsStr, 8'd0, cnt_d, line_d, pos_d);
          k = k + 3'd1;
        end
        default: ;
      endcase
      mode_d  = ModeIdle;
      line_d  = '0;
      pos_d   = '0;
      start_d = '0;
      cnt_d   = '0;
    end
  end

  assign recs_o = recs;
  assign cnt_o  = k;

  // Lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      line_q  <= '0;
      pos_q   <= '0;
      start_q <= '0;
      cnt_q   <= '0;
    end else if (acc_i) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[rtl/slx_out.sv]
// Record group buffer and output register: drains one record per beat.
module slx_out import slx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  rec_t [3:0] recs_i,
  input  logic [2:0] cnt_i,
  input  logic       rdy_i,
  output rec_t       rec_o,
  output logic       last_o,
  output logic       valid_o,
  output grp_st_t    st_o
);

  rec_t [3:0] grp_q;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  rec_t       out_q;
  logic       last_q;
  logic       move, last_move;

  // A record moves when the output register is free or being taken
  assign move      = (cnt_q != 3'd0) && (!valid_q || rdy_i);
  assign last_move = (({1'b0, idx_q} + 3'd1) == cnt_q);

  always_comb begin
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load_i) begin
      cnt_d = cnt_i;
      idx_d = '0;
    end else if (move) begin
      if (last_move) begin
        cnt_d = '0;
        idx_d = '0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
    if (move)       valid_d = 1'b1;
    else if (rdy_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (load_i) grp_q <= recs_i;
    if (move) begin
      out_q  <= grp_q[idx_q];
      last_q <= last_move;
    end
  end

  assign rec_o       = out_q;
  assign last_o      = last_q;
  assign valid_o     = valid_q;
  assign st_o.cnt      = cnt_q;
  assign st_o.can_load = (cnt_q == 3'd0) || (move && last_move);

endmodule

[rtl/script_lexer_unit.sv]
// Top level of the streaming script lexer.
//
// Input stream: one script byte per beat on s_axis_tdata_i, s_axis_tlast_i
// marks the final byte; all lexer state returns to its reset value after it.
// Output stream: one record per beat (token character, token end, or
// unterminated-string error); m_axis_tuser_o carries record kind and token
// class, m_axis_tlast_o marks the last record caused by an input byte.
// A byte may cause zero to four records.
// Each record passes the group buffer register, then the output register.
// Throughput: one byte per cycle while each byte yields at most one record
// and m_axis_tready_i is high; a byte yielding n records sends them one per
// beat, and the next byte is taken in the cycle its predecessor's last record
// moves to the output register. The input side stays ready while one
// finished record waits.
// Stall: when m_axis_tready_i is low the output register holds its record,
// the group buffer fills and s_axis_tready_o drops.
// Reset: asynchronous, active low; lexer idle, line and offset counters zero,
// no records pending.
module script_lexer_unit import slx_pkg::*; #(
  parameter int unsigned MAX_SCRIPT_BYTES = 1048576,
  parameter int unsigned MAX_LINES        = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // byte_value[7:0]
  input  logic        s_axis_tlast_i,   // final_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // char_out[7:0], token_length[27:8],
                                        // line_number[43:28], byte_offset[63:44]
  output logic [3:0]  m_axis_tuser_o,   // record_type[1:0], token_class[3:2]
  output logic        m_axis_tlast_o    // last_of_run
);

  rec_t [3:0] recs;
  logic [2:0] rec_cnt;
  logic       in_acc;
  rec_t       rec;
  grp_st_t    grp_st;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = grp_st.can_load;

  slx_core #(
    .MAX_SCRIPT_BYTES (MAX_SCRIPT_BYTES),
    .MAX_LINES        (MAX_LINES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (in_acc),
    .byte_i (s_axis_tdata_i),
    .fin_i  (s_axis_tlast_i),
    .recs_o (recs),
    .cnt_o  (rec_cnt)
  );

  slx_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_acc),
    .recs_i  (recs),
    .cnt_i   (rec_cnt),
    .rdy_i   (m_axis_tready_i),
    .rec_o   (rec),
    .last_o  (m_axis_tlast_o),
    .valid_o (m_axis_tvalid_o),
    .st_o    (grp_st)
  );

  // Output beat packing
  assign m_axis_tdata_o = {rec.off, rec.line, rec.len, rec.ch};
  assign m_axis_tuser_o = {rec.cls, rec.rtype};

  // Group never holds more records than one byte can cause
  a_grp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_st.cnt <= 3'(MaxRecs))
    else $error("record group count out of range");

  // A byte that yields records leaves them pending in the group
  a_load_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && rec_cnt != 3'd0) |=> (grp_st.cnt != 3'd0))
    else $error("records of an accepted byte were lost");

  // A record that is not the last of its byte is followed by more
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o)
      |=> (m_axis_tvalid_o || grp_st.cnt != 3'd0))
    else $error("record run ended without last flag");

  // Input is held off while a stalled output still has records queued behind it
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i && grp_st.cnt != 3'd0) |-> !s_axis_tready_o)
    else $error("input accepted over pending records");

endmodule
